// File: src/d96r_pkg.sv
// ----------------------------------------------------------------------------
// d96r_pkg: shared types and constants for decimal96 integer rounding
// Holds the mode and state codes, word types and the divide-by-ten constants.
// ----------------------------------------------------------------------------
package d96r_pkg;

   localparam int WORD_W    = 32;
   localparam int NUM_WORDS = 3;
   localparam int SCALE_W   = 5;
   localparam int DIGIT_W   = 4;
   localparam int DIVIDEND_W = DIGIT_W + WORD_W;
   localparam int PRODUCT_W  = DIVIDEND_W + WORD_W;
   localparam int MANT_W     = NUM_WORDS * WORD_W;

   // word positions inside the mantissa, high word is divided first
   localparam logic [1:0] TOP_WORD    = 2'd2;
   localparam logic [1:0] BOTTOM_WORD = 2'd0;

   // floor(2^35 / 10): estimate is at most one below the true quotient
   localparam logic [WORD_W-1:0] RECIP_TEN   = 32'hCCCC_CCCC;
   localparam int                RECIP_SHIFT = 35;

   localparam logic [DIGIT_W-1:0] RADIX      = 4'd10;
   localparam logic [DIGIT_W-1:0] HALF_DIGIT = 4'd5;

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [DIGIT_W-1:0] digit_type;
   typedef logic [SCALE_W-1:0] scale_type;

   typedef enum logic [1:0] {
      MODE_TRUNC,
      MODE_FLOOR,
      MODE_ROUND,
      MODE_NEGATE
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIN
   } state_type;

   typedef struct packed {
      digit_type rem;
      word_type  word;
   } div_in_type;

   typedef struct packed {
      word_type  quot;
      digit_type rem;
   } div_out_type;

endpackage

// File: src/d96r_req_if.sv
// ----------------------------------------------------------------------------
// d96r_req_if: request channel
// Valid/ready channel carrying one decimal word: mode, mantissa, scale, sign.
// ----------------------------------------------------------------------------
interface d96r_req_if import d96r_pkg::*; ();

   logic      valid;
   logic      ready;
   logic [1:0] mode;
   word_type  mant_word0;
   word_type  mant_word1;
   word_type  mant_word2;
   scale_type scale;
   logic      sign;

   modport source (
      output valid, mode, mant_word0, mant_word1, mant_word2, scale, sign,
      input  ready
   );

   modport sink (
      input  valid, mode, mant_word0, mant_word1, mant_word2, scale, sign,
      output ready
   );

endinterface

// File: src/d96r_rsp_if.sv
// ----------------------------------------------------------------------------
// d96r_rsp_if: response channel
// Valid/ready channel carrying one result word: mantissa, scale, sign.
// ----------------------------------------------------------------------------
interface d96r_rsp_if import d96r_pkg::*; ();

   logic      valid;
   logic      ready;
   word_type  res_word0;
   word_type  res_word1;
   word_type  res_word2;
   scale_type res_scale;
   logic      res_sign;

   modport source (
      output valid, res_word0, res_word1, res_word2, res_scale, res_sign,
      input  ready
   );

   modport sink (
      input  valid, res_word0, res_word1, res_word2, res_scale, res_sign,
      output ready
   );

endinterface

// File: src/d96r_div10.sv
// ----------------------------------------------------------------------------
// d96r_div10: shared divide-by-ten unit
// Divides {remainder, word} by ten through a reciprocal multiply and a
// single correction step; returns the quotient word and the new remainder.
// ----------------------------------------------------------------------------
module d96r_div10 import d96r_pkg::*; (
   input  div_in_type  div_in,
   output div_out_type div_out
);

   logic [DIVIDEND_W-1:0] dividend;
   logic [PRODUCT_W-1:0]  product;
   word_type              quot_est;
   logic [DIVIDEND_W-1:0] back;
   logic [DIVIDEND_W-1:0] rem_full;
   logic [DIGIT_W:0]      rem_est;

   // estimate the quotient from the reciprocal
   assign dividend = {div_in.rem, div_in.word};
   assign product  = PRODUCT_W'(dividend) * PRODUCT_W'(RECIP_TEN);
   assign quot_est = product[RECIP_SHIFT +: WORD_W];

   // remainder of the estimate: dividend - 10 * estimate, below twenty
   assign back     = DIVIDEND_W'({quot_est, 3'b000}) + DIVIDEND_W'({quot_est, 1'b0});
   assign rem_full = dividend - back;
   assign rem_est  = rem_full[DIGIT_W:0];

   // correct the estimate by one where the remainder reaches ten
   always_comb begin
      if (rem_est >= (DIGIT_W+1)'(RADIX)) begin
         div_out.quot = quot_est + word_type'(1);
         div_out.rem  = DIGIT_W'(rem_est - (DIGIT_W+1)'(RADIX));
      end else begin
         div_out.quot = quot_est;
         div_out.rem  = DIGIT_W'(rem_est);
      end
   end

endmodule

// File: src/decimal96_integer_rounding.sv
// ----------------------------------------------------------------------------
// decimal96_integer_rounding: truncate, floor, round or negate a 96-bit decimal
// Sequencer around one shared divide-by-ten unit, with a result register.
// ----------------------------------------------------------------------------
// Usage:
//   req_if takes one word (mode, three mantissa words, scale, sign) when
//   valid and ready are both high; ready is high only while the sequencer
//   is idle. rsp_if gives one result word per request.
//   The divider works on one 32-bit mantissa word per cycle, high word
//   first, so one scale step passes over all three words. A result is
//   loaded into the output register from the final state after the scale
//   steps (straight from idle for negate or scale zero), and the increment
//   for floor/round is applied as it is loaded. The single divider and
//   its word loop finish one request before the next one is taken.
//   The next request is accepted while a result waits in the output
//   register; if the receiver stalls, the sequencer holds in its final
//   state until the output register frees up.
//   Reset (synchronous) returns the sequencer to idle and drops any
//   pending result.
// ----------------------------------------------------------------------------
module decimal96_integer_rounding import d96r_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   d96r_req_if.sink   req_if,
   d96r_rsp_if.source rsp_if
);

   state_type   state_ff,  state_in;
   mode_type    mode_ff,   mode_in;
   word_type    w_ff [NUM_WORDS];
   word_type    w_in [NUM_WORDS];
   scale_type   scale_ff,  scale_in;
   logic        sign_ff,   sign_in;
   scale_type   steps_ff,  steps_in;
   logic [1:0]  idx_ff,    idx_in;
   digit_type   rem_ff,    rem_in;
   logic        lost_ff,   lost_in;
   digit_type   last_ff,   last_in;

   logic        out_valid_ff, out_valid_in;
   word_type    out_w0_ff, out_w0_in;
   word_type    out_w1_ff, out_w1_in;
   word_type    out_w2_ff, out_w2_in;
   scale_type   out_scale_ff, out_scale_in;
   logic        out_sign_ff,  out_sign_in;

   div_in_type  div_in;
   div_out_type div_out;
   logic        do_inc;
   logic [MANT_W-1:0] sum;
   logic        out_free;

   // shared divider
   d96r_div10 u_div10 (
      .div_in  (div_in),
      .div_out (div_out)
   );

   assign div_in.rem  = rem_ff;
   assign div_in.word = w_ff[idx_ff];

   // final increment with carry across all words
   assign do_inc = (mode_ff == MODE_FLOOR && sign_ff && lost_ff) ||
                   (mode_ff == MODE_ROUND && last_ff >= HALF_DIGIT);
   assign sum      = {w_ff[2], w_ff[1], w_ff[0]} + MANT_W'(do_inc);
   assign out_free = !out_valid_ff || rsp_if.ready;

   assign req_if.ready     = (state_ff == ST_IDLE);
   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.res_word0 = out_w0_ff;
   assign rsp_if.res_word1 = out_w1_ff;
   assign rsp_if.res_word2 = out_w2_ff;
   assign rsp_if.res_scale = out_scale_ff;
   assign rsp_if.res_sign  = out_sign_ff;

   // sequence next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      w_in         = w_ff;
      scale_in     = scale_ff;
      sign_in      = sign_ff;
      steps_in     = steps_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      lost_in      = lost_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_w0_in    = out_w0_ff;
      out_w1_in    = out_w1_ff;
      out_w2_in    = out_w2_ff;
      out_scale_in = out_scale_ff;
      out_sign_in  = out_sign_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // capture a new word
            if (req_if.valid) begin
               mode_in  = mode_type'(req_if.mode);
               w_in[0]  = req_if.mant_word0;
               w_in[1]  = req_if.mant_word1;
               w_in[2]  = req_if.mant_word2;
               scale_in = req_if.scale;
               sign_in  = req_if.sign;
               steps_in = req_if.scale;
               idx_in   = TOP_WORD;
               rem_in   = '0;
               lost_in  = 1'b0;
               last_in  = '0;
               if (mode_type'(req_if.mode) == MODE_NEGATE || req_if.scale == '0) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // divide one word, carry the remainder downward
            w_in[idx_ff] = div_out.quot;
            rem_in       = div_out.rem;
            if (idx_ff == BOTTOM_WORD) begin
               lost_in  = lost_ff || (div_out.rem != '0);
               last_in  = div_out.rem;
               rem_in   = '0;
               idx_in   = TOP_WORD;
               steps_in = steps_ff - scale_type'(1);
               if (steps_ff == scale_type'(1)) begin
                  state_in = ST_FIN;
               end
            end else begin
               idx_in = idx_ff - 2'd1;
            end
         end
         ST_FIN: begin
            // load the result register once it is free
            if (out_free) begin
               out_valid_in = 1'b1;
               out_w0_in    = sum[0*WORD_W +: WORD_W];
               out_w1_in    = sum[1*WORD_W +: WORD_W];
               out_w2_in    = sum[2*WORD_W +: WORD_W];
               if (mode_ff == MODE_NEGATE) begin
                  out_scale_in = scale_ff;
                  out_sign_in  = !sign_ff;
               end else begin
                  out_scale_in = '0;
                  out_sign_in  = sign_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      w_ff         <= w_in;
      scale_ff     <= scale_in;
      sign_ff      <= sign_in;
      steps_ff     <= steps_in;
      idx_ff       <= idx_in;
      rem_ff       <= rem_in;
      lost_ff      <= lost_in;
      last_ff      <= last_in;
      out_w0_ff    <= out_w0_in;
      out_w1_ff    <= out_w1_in;
      out_w2_ff    <= out_w2_in;
      out_scale_ff <= out_scale_in;
      out_sign_ff  <= out_sign_in;
   end

   // a division step never runs with its step count used up
   a_steps_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> steps_ff != '0)
      else $error("division running with no steps left");

   // the word pointer stays on a mantissa word
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> idx_ff <= TOP_WORD)
      else $error("word pointer out of range");

   // the divider hands back a decimal digit while a division runs
   a_rem_digit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> div_out.rem < RADIX)
      else $error("divider remainder not below ten");

   // a result appears only out of the final state
   a_result_src: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result loaded outside the final state");

endmodule
